FILE: rtl/core/sqg_pkg.sv
// Shared types and constants for the single-qubit gate datapath.
`default_nettype none
package sqg_pkg;

  localparam int DATA_W        = 32;
  localparam int ADDR_W        = 24;
  localparam int COEF_W        = 64;
  localparam int FRAC_W        = 30;
  localparam int PROD_W        = 2 * DATA_W;
  localparam int SUM_W         = PROD_W + 2;
  localparam int NUM_LANES     = 4;
  localparam int NUM_TERMS     = 4;
  localparam int TQ_W          = 5;
  localparam int CFG_IDX_W     = 3;
  localparam int UNIT_BITS_DEF = 24;

  localparam logic [COEF_W-1:0] COEF_ONE  = 64'h4000_0000_0000_0000;
  localparam logic [COEF_W-1:0] COEF_ZERO = '0;

  localparam logic signed [DATA_W-1:0] SAT_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [DATA_W-1:0] SAT_MIN = 32'sh8000_0000;

  // real part: terms 1 and 3 (imag * imag) are subtracted
  localparam logic [NUM_TERMS-1:0] SUB_RE = 4'b1010;
  localparam logic [NUM_TERMS-1:0] SUB_IM = 4'b0000;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_COEF_00      = 3'd0,
    CFG_COEF_01      = 3'd1,
    CFG_COEF_10      = 3'd2,
    CFG_COEF_11      = 3'd3,
    CFG_TARGET_QUBIT = 3'd4,
    CFG_SPLIT_MODE   = 3'd5,
    CFG_WRITE_MASK   = 3'd6
  } cfg_idx_t;

  typedef struct packed {
    logic ld_mul;
    logic ld_sum;
  } lane_ctl_t;

  typedef struct packed {
    logic [ADDR_W-1:0] addr_first;
    logic [ADDR_W-1:0] addr_second;
    logic              write_first;
    logic              write_second;
  } meta_t;

endpackage
`default_nettype wire

FILE: rtl/core/sqg_addr.sv
// Pair address generation and write enables.
`default_nettype none
module sqg_addr #(
  parameter int UNIT_BITS = sqg_pkg::UNIT_BITS_DEF
) (
  input  wire logic [sqg_pkg::ADDR_W-1:0] pair_index,
  input  wire logic [sqg_pkg::TQ_W-1:0]   target_qubit,
  input  wire logic                       split_mode,
  input  wire logic [1:0]                 write_mask,
  output sqg_pkg::meta_t                  meta
);
  import sqg_pkg::*;

  logic [ADDR_W-1:0] tbit;
  logic [ADDR_W-1:0] low_m;
  logic [ADDR_W-1:0] a0;
  logic [ADDR_W-1:0] a1;
  logic [ADDR_W-1:0] umask;

  always_comb begin
    for (int i = 0; i < ADDR_W; i++) begin
      umask[i] = (i < UNIT_BITS);
    end
    tbit  = ADDR_W'(1) << target_qubit;
    low_m = tbit - ADDR_W'(1);
    a0    = ((pair_index & ~low_m) << 1) | (pair_index & low_m);
    a1    = a0 + tbit;
    if (split_mode) begin
      meta.addr_first   = pair_index & umask;
      meta.addr_second  = pair_index & umask;
      meta.write_first  = write_mask[0];
      meta.write_second = write_mask[1];
    end else begin
      meta.addr_first   = a0 & umask;
      meta.addr_second  = a1 & umask;
      meta.write_first  = 1'b1;
      meta.write_second = 1'b1;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/core/sqg_lane.sv
// One result component: four products, exact sum, shift and saturate.
`default_nettype none
module sqg_lane (
  input  wire logic                              clk,
  input  wire sqg_pkg::lane_ctl_t                ctl,
  input  wire logic [sqg_pkg::NUM_TERMS-1:0]     sub_mask,
  input  wire logic signed [sqg_pkg::DATA_W-1:0] coef [sqg_pkg::NUM_TERMS],
  input  wire logic signed [sqg_pkg::DATA_W-1:0] amp [sqg_pkg::NUM_TERMS],
  output logic signed [sqg_pkg::DATA_W-1:0]      res,
  output logic                                   clip
);
  import sqg_pkg::*;

  logic signed [PROD_W-1:0] prod_r   [NUM_TERMS];
  logic signed [PROD_W-1:0] prod_nxt [NUM_TERMS];
  logic [NUM_TERMS-1:0]     sub_r;
  logic signed [SUM_W-1:0]  term     [NUM_TERMS];
  logic signed [SUM_W-1:0]  sum_r;
  logic signed [SUM_W-1:0]  sum_nxt;
  logic                     fits;

  always_comb begin
    for (int k = 0; k < NUM_TERMS; k++) begin
      prod_nxt[k] = coef[k] * amp[k];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.ld_mul) begin
      for (int k = 0; k < NUM_TERMS; k++) begin
        prod_r[k] <= prod_nxt[k];
      end
      sub_r <= sub_mask;
    end
  end

  always_comb begin
    for (int k = 0; k < NUM_TERMS; k++) begin
      term[k] = sub_r[k] ? -SUM_W'(prod_r[k]) : SUM_W'(prod_r[k]);
    end
    sum_nxt = (term[0] + term[1]) + (term[2] + term[3]);
  end

  always_ff @(posedge clk) begin
    if (ctl.ld_sum) begin
      sum_r <= sum_nxt;
    end
  end

  // result fits when every bit above the kept window, and the window's top bit, equals the sign
  always_comb begin
    fits = (sum_r[SUM_W-1:FRAC_W+DATA_W-1] == {(SUM_W-FRAC_W-DATA_W+1){sum_r[SUM_W-1]}});
    clip = !fits;
    if (fits) begin
      res = sum_r[FRAC_W+DATA_W-1:FRAC_W];
    end else if (sum_r[SUM_W-1]) begin
      res = SAT_MIN;
    end else begin
      res = SAT_MAX;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/core/sqg_merge.sv
// Output register: gathers lane results, addresses, write enables and the clip flag.
`default_nettype none
module sqg_merge (
  input  wire logic                              clk,
  input  wire logic                              ld,
  input  wire sqg_pkg::meta_t                    meta,
  input  wire logic signed [sqg_pkg::DATA_W-1:0] res [sqg_pkg::NUM_LANES],
  input  wire logic [sqg_pkg::NUM_LANES-1:0]     clip,
  output logic [sqg_pkg::ADDR_W-1:0]             addr_first,
  output logic [sqg_pkg::ADDR_W-1:0]             addr_second,
  output logic signed [sqg_pkg::DATA_W-1:0]      new0_re,
  output logic signed [sqg_pkg::DATA_W-1:0]      new0_im,
  output logic signed [sqg_pkg::DATA_W-1:0]      new1_re,
  output logic signed [sqg_pkg::DATA_W-1:0]      new1_im,
  output logic                                   write_first,
  output logic                                   write_second,
  output logic                                   clipped
);
  import sqg_pkg::*;

  logic clipped_nxt;

  assign clipped_nxt = |clip;

  always_ff @(posedge clk) begin
    if (ld) begin
      addr_first   <= meta.addr_first;
      addr_second  <= meta.addr_second;
      write_first  <= meta.write_first;
      write_second <= meta.write_second;
      new0_re      <= res[0];
      new0_im      <= res[1];
      new1_re      <= res[2];
      new1_im      <= res[3];
      clipped      <= clipped_nxt;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/core/single_qubit_gate_apply.sv
// Single-qubit gate unit: 2x2 complex matrix on one amplitude pair per transfer.
// 3 register stages (multiply, sum, output); out_valid is the output stage's valid flag.
// Throughput: one pair per cycle while out_ready is high; four lanes, one per result
// component, run in parallel. A full stage holds while the next is full and stalled, so
// bubbles close up under output stalls. Reset (synchronous, active low) empties the
// pipeline and loads the identity matrix, target 0, local mode and write mask 3.
`default_nettype none
module single_qubit_gate_apply #(
  parameter int UNIT_BITS = sqg_pkg::UNIT_BITS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic [sqg_pkg::ADDR_W-1:0]        in_pair_index,
  input  wire logic signed [sqg_pkg::DATA_W-1:0] in_amp0_re,
  input  wire logic signed [sqg_pkg::DATA_W-1:0] in_amp0_im,
  input  wire logic signed [sqg_pkg::DATA_W-1:0] in_amp1_re,
  input  wire logic signed [sqg_pkg::DATA_W-1:0] in_amp1_im,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic [sqg_pkg::ADDR_W-1:0]             out_addr_first,
  output logic [sqg_pkg::ADDR_W-1:0]             out_addr_second,
  output logic signed [sqg_pkg::DATA_W-1:0]      out_new0_re,
  output logic signed [sqg_pkg::DATA_W-1:0]      out_new0_im,
  output logic signed [sqg_pkg::DATA_W-1:0]      out_new1_re,
  output logic signed [sqg_pkg::DATA_W-1:0]      out_new1_im,
  output logic                                   out_write_first,
  output logic                                   out_write_second,
  output logic                                   out_clipped,
  input  wire logic                              cfg_we,
  input  wire logic [sqg_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [sqg_pkg::COEF_W-1:0]        cfg_wdata
);
  import sqg_pkg::*;

  logic [COEF_W-1:0] coef_00_r;
  logic [COEF_W-1:0] coef_01_r;
  logic [COEF_W-1:0] coef_10_r;
  logic [COEF_W-1:0] coef_11_r;
  logic [TQ_W-1:0]   target_qubit_r;
  logic              split_mode_r;
  logic [1:0]        write_mask_r;

  logic      v1_r, v2_r, v3_r;
  logic      v1_nxt, v2_nxt, v3_nxt;
  logic      rdy1, rdy2, rdy3;
  lane_ctl_t lane_ctl;
  meta_t     meta_nxt;
  meta_t     meta1_r;
  meta_t     meta2_r;

  logic signed [DATA_W-1:0] lane_coef [NUM_LANES][NUM_TERMS];
  logic signed [DATA_W-1:0] lane_amp  [NUM_LANES][NUM_TERMS];
  logic [NUM_TERMS-1:0]     lane_sub  [NUM_LANES];
  logic signed [DATA_W-1:0] lane_res  [NUM_LANES];
  logic [NUM_LANES-1:0]     lane_clip;
  logic [COEF_W-1:0]        row_a;
  logic [COEF_W-1:0]        row_b;

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_00_r      <= COEF_ONE;
      coef_01_r      <= COEF_ZERO;
      coef_10_r      <= COEF_ZERO;
      coef_11_r      <= COEF_ONE;
      target_qubit_r <= '0;
      split_mode_r   <= 1'b0;
      write_mask_r   <= 2'b11;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_COEF_00:      coef_00_r      <= cfg_wdata;
        CFG_COEF_01:      coef_01_r      <= cfg_wdata;
        CFG_COEF_10:      coef_10_r      <= cfg_wdata;
        CFG_COEF_11:      coef_11_r      <= cfg_wdata;
        CFG_TARGET_QUBIT: target_qubit_r <= cfg_wdata[TQ_W-1:0];
        CFG_SPLIT_MODE:   split_mode_r   <= cfg_wdata[0];
        CFG_WRITE_MASK:   write_mask_r   <= cfg_wdata[1:0];
        default: ;
      endcase
    end
  end

  // pipeline control
  assign rdy3     = !v3_r || out_ready;
  assign rdy2     = !v2_r || rdy3;
  assign rdy1     = !v1_r || rdy2;
  assign in_ready = rdy1;
  assign out_valid = v3_r;

  assign lane_ctl.ld_mul = rdy1;
  assign lane_ctl.ld_sum = rdy2;

  always_comb begin
    v1_nxt = rdy1 ? in_valid : v1_r;
    v2_nxt = rdy2 ? v1_r : v2_r;
    v3_nxt = rdy3 ? v2_r : v3_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= v1_nxt;
      v2_r <= v2_nxt;
      v3_r <= v3_nxt;
    end
  end

  sqg_addr #(
    .UNIT_BITS(UNIT_BITS)
  ) u_addr (
    .pair_index  (in_pair_index),
    .target_qubit(target_qubit_r),
    .split_mode  (split_mode_r),
    .write_mask  (write_mask_r),
    .meta        (meta_nxt)
  );

  always_ff @(posedge clk) begin
    if (rdy1) begin
      meta1_r <= meta_nxt;
    end
    if (rdy2) begin
      meta2_r <= meta1_r;
    end
  end

  // lane operands: lanes 0/1 are row 0 re/im, lanes 2/3 row 1 re/im
  always_comb begin
    for (int l = 0; l < NUM_LANES; l++) begin
      row_a = (l >= 2) ? coef_10_r : coef_00_r;
      row_b = (l >= 2) ? coef_11_r : coef_01_r;
      lane_coef[l][0] = row_a[COEF_W-1:DATA_W];
      lane_coef[l][1] = row_a[DATA_W-1:0];
      lane_coef[l][2] = row_b[COEF_W-1:DATA_W];
      lane_coef[l][3] = row_b[DATA_W-1:0];
      if (l % 2 == 1) begin
        lane_amp[l][0] = in_amp0_im;
        lane_amp[l][1] = in_amp0_re;
        lane_amp[l][2] = in_amp1_im;
        lane_amp[l][3] = in_amp1_re;
        lane_sub[l]    = SUB_IM;
      end else begin
        lane_amp[l][0] = in_amp0_re;
        lane_amp[l][1] = in_amp0_im;
        lane_amp[l][2] = in_amp1_re;
        lane_amp[l][3] = in_amp1_im;
        lane_sub[l]    = SUB_RE;
      end
    end
  end

  for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
    sqg_lane u_lane (
      .clk     (clk),
      .ctl     (lane_ctl),
      .sub_mask(lane_sub[g]),
      .coef    (lane_coef[g]),
      .amp     (lane_amp[g]),
      .res     (lane_res[g]),
      .clip    (lane_clip[g])
    );
  end

  sqg_merge u_merge (
    .clk         (clk),
    .ld          (rdy3),
    .meta        (meta2_r),
    .res         (lane_res),
    .clip        (lane_clip),
    .addr_first  (out_addr_first),
    .addr_second (out_addr_second),
    .new0_re     (out_new0_re),
    .new0_im     (out_new0_im),
    .new1_re     (out_new1_re),
    .new1_im     (out_new1_im),
    .write_first (out_write_first),
    .write_second(out_write_second),
    .clipped     (out_clipped)
  );

  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (v1_r && v2_r && v3_r && !out_ready))
    else $error("input stalled with a free pipeline stage");

  a_clip_sat: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_clipped) |->
      (out_new0_re == SAT_MAX || out_new0_re == SAT_MIN ||
       out_new0_im == SAT_MAX || out_new0_im == SAT_MIN ||
       out_new1_re == SAT_MAX || out_new1_re == SAT_MIN ||
       out_new1_im == SAT_MAX || out_new1_im == SAT_MIN))
    else $error("clip flagged without a saturated component");

  a_addr_pair: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_addr_first == out_addr_second) ||
                   $onehot(out_addr_first ^ out_addr_second)))
    else $error("pair addresses differ by more than the target bit");

  a_mask_split: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (!out_write_first || !out_write_second)) |->
      (out_addr_first == out_addr_second))
    else $error("write disabled on a local-mode pair");

endmodule
`default_nettype wire

FILE: test/single_qubit_gate_apply_test.sv
// Self-checking testbench for single_qubit_gate_apply: random and directed amplitude pairs.
module single_qubit_gate_apply_test;
  timeunit 1ns;
  timeprecision 1ps;

  import sqg_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int RANDOM_PHASES = 12;
  localparam int PAIRS_PER_PHASE = 108;
  localparam logic signed [67:0] ACC_HI = 68'sd2147483647;
  localparam logic signed [67:0] ACC_LO = -68'sd2147483648;

  typedef struct packed {
    logic [ADDR_W-1:0] pair_index;
    logic [DATA_W-1:0] amp0_re;
    logic [DATA_W-1:0] amp0_im;
    logic [DATA_W-1:0] amp1_re;
    logic [DATA_W-1:0] amp1_im;
  } amp_pair_t;

  typedef struct packed {
    logic [ADDR_W-1:0] addr_first;
    logic [ADDR_W-1:0] addr_second;
    logic [DATA_W-1:0] new0_re;
    logic [DATA_W-1:0] new0_im;
    logic [DATA_W-1:0] new1_re;
    logic [DATA_W-1:0] new1_im;
    logic              write_first;
    logic              write_second;
    logic              clipped;
  } amp_update_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [ADDR_W-1:0] in_pair_index = '0;
  logic signed [DATA_W-1:0] in_amp0_re = '0;
  logic signed [DATA_W-1:0] in_amp0_im = '0;
  logic signed [DATA_W-1:0] in_amp1_re = '0;
  logic signed [DATA_W-1:0] in_amp1_im = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [ADDR_W-1:0] out_addr_first;
  logic [ADDR_W-1:0] out_addr_second;
  logic signed [DATA_W-1:0] out_new0_re;
  logic signed [DATA_W-1:0] out_new0_im;
  logic signed [DATA_W-1:0] out_new1_re;
  logic signed [DATA_W-1:0] out_new1_im;
  logic out_write_first;
  logic out_write_second;
  logic out_clipped;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [COEF_W-1:0] cfg_wdata = '0;

  // shadow copy of the gate registers
  logic [COEF_W-1:0] gate_coef [4];
  logic [TQ_W-1:0] gate_target;
  logic gate_split;
  logic [1:0] gate_mask;

  amp_pair_t pending_pairs[$];
  amp_update_t predicted_updates[$];
  int errors = 0;
  int cycle_count = 0;
  int sender_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_left = 0;
  bit hold_req = 1'b0;
  bit in_took = 1'b0;

  single_qubit_gate_apply uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_pair_index(in_pair_index),
    .in_amp0_re(in_amp0_re),
    .in_amp0_im(in_amp0_im),
    .in_amp1_re(in_amp1_re),
    .in_amp1_im(in_amp1_im),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_addr_first(out_addr_first),
    .out_addr_second(out_addr_second),
    .out_new0_re(out_new0_re),
    .out_new0_im(out_new0_im),
    .out_new1_re(out_new1_re),
    .out_new1_im(out_new1_im),
    .out_write_first(out_write_first),
    .out_write_second(out_write_second),
    .out_clipped(out_clipped),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  always #5 clk = ~clk;

  // {clip, value}: arithmetic shift by 30, then saturate to 32 bits
  function automatic logic [32:0] sat_q30(input logic signed [67:0] acc);
    logic signed [67:0] q;
    q = acc >>> FRAC_W;
    if (q > ACC_HI) return {1'b1, SAT_MAX};
    if (q < ACC_LO) return {1'b1, SAT_MIN};
    return {1'b0, q[31:0]};
  endfunction

  // one matrix row times the amplitude pair: {sat re, sat im}
  function automatic logic [65:0] row_product(input logic [COEF_W-1:0] ca,
                                              input logic [COEF_W-1:0] cb,
                                              input amp_pair_t p);
    logic signed [31:0] ar, ai, br, bi, x0r, x0i, x1r, x1i;
    logic signed [67:0] acc_re, acc_im;
    ar = ca[63:32];
    ai = ca[31:0];
    br = cb[63:32];
    bi = cb[31:0];
    x0r = p.amp0_re;
    x0i = p.amp0_im;
    x1r = p.amp1_re;
    x1i = p.amp1_im;
    acc_re = ar * x0r - ai * x0i + br * x1r - bi * x1i;
    acc_im = ar * x0i + ai * x0r + br * x1i + bi * x1r;
    return {sat_q30(acc_re), sat_q30(acc_im)};
  endfunction

  function automatic amp_update_t apply_gate(input amp_pair_t p);
    amp_update_t r;
    logic [63:0] idx, bitv, low, a0, a1;
    logic [65:0] row0, row1;
    idx = {40'd0, p.pair_index};
    if (gate_split) begin
      a0 = idx;
      a1 = idx;
      r.write_first = gate_mask[0];
      r.write_second = gate_mask[1];
    end else begin
      bitv = 64'd1 << gate_target;
      low = idx & (bitv - 64'd1);
      a0 = ((idx - low) << 1) + low;
      a1 = a0 + bitv;
      r.write_first = 1'b1;
      r.write_second = 1'b1;
    end
    r.addr_first = a0[ADDR_W-1:0];
    r.addr_second = a1[ADDR_W-1:0];
    row0 = row_product(gate_coef[0], gate_coef[1], p);
    row1 = row_product(gate_coef[2], gate_coef[3], p);
    r.new0_re = row0[64:33];
    r.new0_im = row0[31:0];
    r.new1_re = row1[64:33];
    r.new1_im = row1[31:0];
    r.clipped = row0[65] | row0[32] | row1[65] | row1[32];
    return r;
  endfunction

  function automatic logic [31:0] rand_q30();
    logic [31:0] v;
    v = $urandom;
    case ($urandom_range(9))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'h0;
      3: return 32'hFFFF_FFFF;
      4, 5, 6: return {{2{v[31]}}, v[29:0]};
      default: return v;
    endcase
  endfunction

  function automatic logic [31:0] rand_coef_part();
    logic [31:0] v;
    v = $urandom;
    case ($urandom_range(7))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'h4000_0000;
      3: return 32'hC000_0000;
      4: return 32'h0;
      5, 6: return {{2{v[31]}}, v[29:0]};
      default: return v;
    endcase
  endfunction

  function automatic amp_pair_t rand_pair();
    amp_pair_t p;
    case ($urandom_range(9))
      0: p.pair_index = '0;
      1: p.pair_index = '1;
      default: p.pair_index = ADDR_W'($urandom);
    endcase
    p.amp0_re = rand_q30();
    p.amp0_im = rand_q30();
    p.amp1_re = rand_q30();
    p.amp1_im = rand_q30();
    return p;
  endfunction

  task automatic write_reg(input cfg_idx_t idx, input logic [COEF_W-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      CFG_COEF_00, CFG_COEF_01, CFG_COEF_10, CFG_COEF_11: gate_coef[idx[1:0]] = val;
      CFG_TARGET_QUBIT: gate_target = val[TQ_W-1:0];
      CFG_SPLIT_MODE: gate_split = val[0];
      CFG_WRITE_MASK: gate_mask = val[1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic add_pair(input logic [ADDR_W-1:0] idx, input logic [31:0] a0r,
                          input logic [31:0] a0i, input logic [31:0] a1r,
                          input logic [31:0] a1i);
    pending_pairs.push_back({idx, a0r, a0i, a1r, a1i});
  endtask

  task automatic drain();
    while (!(pending_pairs.size() == 0 && !in_valid && predicted_updates.size() == 0)) begin
      @(negedge clk);
      #1;
    end
    repeat (4) @(negedge clk);
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      errors++;
      if (errors <= 40)
        $display("%0t: %s expected %h actual %h", $time, name, want, got);
    end
  endtask

  // sender
  always @(negedge clk) begin
    if (rst_n && (!in_valid || in_took)) begin
      if (pending_pairs.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
        amp_pair_t p;
        p = pending_pairs.pop_front();
        in_valid <= 1'b1;
        in_pair_index <= p.pair_index;
        in_amp0_re <= p.amp0_re;
        in_amp0_im <= p.amp0_im;
        in_amp1_re <= p.amp1_re;
        in_amp1_im <= p.amp1_im;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver, with a long hold-off on request
  always @(negedge clk) begin
    if (hold_req) begin
      hold_left = 300;
      hold_req = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // transfer monitor and scoreboard
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("single_qubit_gate_apply_test: FAIL");
      $finish;
    end
    in_took = rst_n && in_valid && in_ready;
    if (in_took)
      predicted_updates.push_back(apply_gate({in_pair_index, in_amp0_re, in_amp0_im,
                                              in_amp1_re, in_amp1_im}));
    if (rst_n && out_valid && out_ready) begin
      if (predicted_updates.size() == 0) begin
        errors++;
        $display("%0t: result transfer with nothing expected", $time);
      end else begin
        amp_update_t e;
        e = predicted_updates.pop_front();
        check_field("addr_first", 32'(e.addr_first), 32'(out_addr_first));
        check_field("addr_second", 32'(e.addr_second), 32'(out_addr_second));
        check_field("new0_re", e.new0_re, out_new0_re);
        check_field("new0_im", e.new0_im, out_new0_im);
        check_field("new1_re", e.new1_re, out_new1_re);
        check_field("new1_im", e.new1_im, out_new1_im);
        check_field("write_first", 32'(e.write_first), 32'(out_write_first));
        check_field("write_second", 32'(e.write_second), 32'(out_write_second));
        check_field("clipped", 32'(e.clipped), 32'(out_clipped));
      end
    end
  end

  initial begin
    gate_coef[0] = COEF_ONE;
    gate_coef[1] = COEF_ZERO;
    gate_coef[2] = COEF_ZERO;
    gate_coef[3] = COEF_ONE;
    gate_target = '0;
    gate_split = 1'b0;
    gate_mask = 2'd3;
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;

    // identity after reset, field extremes
    add_pair(24'h000000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
    add_pair(24'hFFFFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
    add_pair(24'hAAAAAA, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0001);
    add_pair(24'h555555, 32'h4000_0000, 32'hC000_0000, 32'h0000_0001, 32'hFFFF_FFFF);
    drain();

    // extreme coefficients, saturation; local mode ignores the mask
    write_reg(CFG_COEF_00, 64'h7FFF_FFFF_7FFF_FFFF);
    write_reg(CFG_COEF_01, 64'h8000_0000_8000_0000);
    write_reg(CFG_COEF_10, 64'h8000_0000_7FFF_FFFF);
    write_reg(CFG_COEF_11, 64'hFFFF_FFFF_FFFF_FFFF);
    write_reg(CFG_TARGET_QUBIT, 64'd23);
    write_reg(CFG_SPLIT_MODE, 64'd0);
    write_reg(CFG_WRITE_MASK, 64'd0);
    add_pair(24'hFFFFFF, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    add_pair(24'h7FFFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000);
    add_pair(24'h000000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
    add_pair(24'h123456, 32'h0000_0001, 32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0000);
    drain();

    // split mode, swap gate, write masks 1 and 2
    write_reg(CFG_COEF_00, COEF_ZERO);
    write_reg(CFG_COEF_01, COEF_ONE);
    write_reg(CFG_COEF_10, COEF_ONE);
    write_reg(CFG_COEF_11, COEF_ZERO);
    write_reg(CFG_TARGET_QUBIT, 64'd31);
    write_reg(CFG_SPLIT_MODE, 64'd1);
    write_reg(CFG_WRITE_MASK, 64'd1);
    add_pair(24'hFFFFFF, 32'h1234_5678, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFEDC_BA98);
    add_pair(24'h000001, 32'h0000_0000, 32'h0000_0001, 32'hFFFF_FFFF, 32'h4000_0000);
    drain();
    write_reg(CFG_WRITE_MASK, 64'd2);
    add_pair(24'h800000, 32'h3333_3333, 32'hCCCC_CCCC, 32'h0F0F_0F0F, 32'hF0F0_F0F0);
    add_pair(24'h000000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    drain();
    // both writes disabled, still computed and clipping
    write_reg(CFG_WRITE_MASK, 64'd0);
    write_reg(CFG_COEF_00, 64'h8000_0000_0000_0000);
    add_pair(24'h00FFFF, 32'h8000_0000, 32'h0000_0000, 32'h0000_0001, 32'h0000_0000);
    add_pair(24'hFF0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF);
    drain();

    // local mode with the target beyond the unit, then back at 0
    write_reg(CFG_SPLIT_MODE, 64'd0);
    add_pair(24'hFFFFFF, 32'h0000_0001, 32'h0000_0002, 32'h0000_0003, 32'h0000_0004);
    add_pair(24'h5A5A5A, 32'h7FFF_FFFF, 32'h0000_0000, 32'h0000_0000, 32'h7FFF_FFFF);
    drain();
    write_reg(CFG_TARGET_QUBIT, 64'd24);
    add_pair(24'hFFFFFF, 32'hFFFF_FFFF, 32'h0000_0001, 32'h8000_0000, 32'h7FFF_FFFF);
    add_pair(24'h000001, 32'h4000_0000, 32'h4000_0000, 32'hC000_0000, 32'hC000_0000);
    drain();
    write_reg(CFG_TARGET_QUBIT, 64'd0);
    add_pair(24'hFFFFFF, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
    drain();

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      write_reg(CFG_COEF_00, {rand_coef_part(), rand_coef_part()});
      write_reg(CFG_COEF_01, {rand_coef_part(), rand_coef_part()});
      write_reg(CFG_COEF_10, {rand_coef_part(), rand_coef_part()});
      write_reg(CFG_COEF_11, {rand_coef_part(), rand_coef_part()});
      case ($urandom_range(3))
        0: write_reg(CFG_TARGET_QUBIT, 64'd0);
        1: write_reg(CFG_TARGET_QUBIT, 64'd23);
        2: write_reg(CFG_TARGET_QUBIT, 64'($urandom_range(31)));
        default: write_reg(CFG_TARGET_QUBIT, 64'($urandom_range(23)));
      endcase
      write_reg(CFG_SPLIT_MODE, 64'($urandom_range(1)));
      write_reg(CFG_WRITE_MASK, 64'($urandom_range(3)));
      case (ph % 4)
        0: begin sender_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin sender_idle_pct = 80; recv_stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  recv_stall_pct = 80; end
        default: begin sender_idle_pct = 16; recv_stall_pct = 16; end
      endcase
      if (ph == 4) hold_req = 1'b1;
      for (int n = 0; n < PAIRS_PER_PHASE; n++)
        pending_pairs.push_back(rand_pair());
      drain();
    end

    repeat (6) @(negedge clk);
    if (errors == 0 && predicted_updates.size() == 0) begin
      $display("single_qubit_gate_apply_test: PASS");
    end else begin
      $display("single_qubit_gate_apply_test: FAIL");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/core/sqg_pkg.sv
rtl/core/sqg_addr.sv
rtl/core/sqg_lane.sv
rtl/core/sqg_merge.sv
rtl/core/single_qubit_gate_apply.sv
test/single_qubit_gate_apply_test.sv
